@@ src/rmd_pkg.sv @@
// Shared types and constants for the RTPS message deframer.
// No dependencies; imported by every module of the block.
package rmd_pkg;

  localparam int unsigned OutDataW = 240;
  localparam int unsigned HdrBytes = 20;
  localparam int unsigned FixedPart = 16;
  localparam logic [7:0] IdData = 8'h15;
  localparam logic [15:0] PidEnd = 16'h0001;
  localparam logic [15:0] SchemePlCdr = 16'h0003;
  localparam int unsigned FlagLe = 0;
  localparam int unsigned FlagQos = 1;
  localparam int unsigned FlagData = 2;

  typedef enum logic [3:0] {
    PH_HEADER, PH_DRAIN, PH_SUBHDR, PH_ALIGN, PH_SKIP, PH_DFIX,
    PH_EXTRA, PH_QOSHDR, PH_QOSSKIP, PH_ENCAP, PH_PAYLOAD
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PREFIX = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_COMMIT = 3'd2,
    KIND_DISCARD = 3'd3,
    KIND_END = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_SHORT = 2'd1,
    ST_BAD_MAGIC = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  cnt;
    kind_e [2:0] kinds;
    logic [7:0]  payload_byte;
    logic [31:0] reader_id;
    logic [31:0] writer_id;
    logic [63:0] sequence_number;
    logic        pl_cdr;
    logic [31:0] prefix_high;
    logic [63:0] prefix_low;
    status_e     status;
  } grp_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h52;
      2'd1: r = 8'h54;
      2'd2: r = 8'h50;
      default: r = 8'h53;
    endcase
    return r;
  endfunction

endpackage

@@ src/rmd_parser.sv @@
// Per-byte parse state and step logic: one byte in, a group of up to three results out.
// Depends on rmd_pkg.
module rmd_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        eom_i,
  output rmd_pkg::grp_t grp_o
);
  import rmd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  hc_q, hc_d;
  logic [1:0]  pos_q, pos_d;
  logic        magic_q, magic_d;
  logic [7:0]  prefix_q [12];
  logic [7:0]  prefix_d [12];
  logic [31:0] sh_q, sh_d;
  logic [15:0] content_q, content_d;
  logic        rest_q, rest_d;
  logic [31:0] fg_q, fg_d;
  logic [15:0] extra_q, extra_d;
  logic [15:0] qos_q, qos_d;
  logic [31:0] reader_q, reader_d;
  logic [31:0] writer_q, writer_d;
  logic [63:0] seq_q, seq_d;
  logic        open_q, open_d;
  logic [2:0]  flags_q, flags_d;

  always_comb begin
    logic       in_content;
    logic [1:0] n;
    logic [15:0] len;
    logic       emit_prefix;
    logic       go_after_extra;
    logic       go_encap;
    logic       go_qoshdr;
    phase_d = phase_q;
    hc_d = hc_q;
    magic_d = magic_q;
    prefix_d = prefix_q;
    sh_d = sh_q;
    content_d = content_q;
    rest_d = rest_q;
    fg_d = fg_q;
    extra_d = extra_q;
    qos_d = qos_q;
    reader_d = reader_q;
    writer_d = writer_q;
    seq_d = seq_q;
    open_d = open_q;
    flags_d = flags_q;
    grp_o = '0;
    n = 2'd0;
    len = '0;
    emit_prefix = 1'b0;
    go_after_extra = 1'b0;
    go_encap = 1'b0;
    go_qoshdr = 1'b0;
    in_content = (phase_q >= PH_SKIP);
    pos_d = pos_q + 2'd1;

    case (phase_q)
      PH_HEADER: begin
        if (hc_q < 5'd4 && data_byte_i != magic_byte(hc_q[1:0])) magic_d = 1'b0;
        if (hc_q >= 5'd8) prefix_d[4'(hc_q - 5'd8)] = data_byte_i;
        hc_d = hc_q + 5'd1;
        if (hc_d >= 5'(HdrBytes)) begin
          hc_d = '0;
          if (magic_d) begin
            emit_prefix = 1'b1;
            phase_d = PH_SUBHDR;
          end else begin
            phase_d = PH_DRAIN;
          end
        end
      end
      PH_SUBHDR: begin
        sh_d = {sh_q[23:0], data_byte_i};
        hc_d = hc_q + 5'd1;
        if (hc_d >= 5'd4) begin
          flags_d = sh_d[18:16];
          len = sh_d[16+FlagLe] ? {sh_d[7:0], sh_d[15:8]} : sh_d[15:0];
          hc_d = '0;
          content_d = len;
          rest_d = (len == 16'd0);
          if (sh_d[31:24] == IdData && sh_d[16+FlagLe]) begin
            phase_d = PH_DFIX;
            reader_d = '0;
            writer_d = '0;
            seq_d = '0;
            fg_d = '0;
            extra_d = '0;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_ALIGN: begin
        if (pos_d == 2'd0) begin
          phase_d = PH_SUBHDR;
          hc_d = '0;
        end
      end
      PH_DFIX: begin
        if (hc_q == 5'd2) extra_d = {8'd0, data_byte_i};
        else if (hc_q == 5'd3) extra_d = {data_byte_i, extra_q[7:0]};
        else if (hc_q >= 5'd4 && hc_q < 5'd8) reader_d = {reader_q[23:0], data_byte_i};
        else if (hc_q >= 5'd8 && hc_q < 5'd12) writer_d = {writer_q[23:0], data_byte_i};
        else if (hc_q >= 5'd12 && hc_q < 5'd16)
          seq_d[{1'b1, hc_q[1:0]}*8 +: 8] = data_byte_i;
        else if (hc_q >= 5'd16 && hc_q < 5'd20)
          seq_d[{1'b0, hc_q[1:0]}*8 +: 8] = data_byte_i;
        hc_d = hc_q + 5'd1;
        if (hc_d >= 5'(HdrBytes)) begin
          hc_d = '0;
          if (extra_d > 16'(FixedPart)) begin
            extra_d = extra_d - 16'(FixedPart);
            phase_d = PH_EXTRA;
          end else begin
            extra_d = '0;
            go_after_extra = 1'b1;
          end
        end
      end
      PH_EXTRA: begin
        if (extra_q != 16'd0) extra_d = extra_q - 16'd1;
        if (extra_d == 16'd0) go_after_extra = 1'b1;
      end
      PH_QOSHDR: begin
        fg_d[hc_q[1:0]*8 +: 8] = data_byte_i;
        hc_d = hc_q + 5'd1;
        if (hc_d >= 5'd4) begin
          hc_d = '0;
          if (fg_d[15:0] == PidEnd) go_encap = 1'b1;
          else if (fg_d[31:16] == 16'd0) go_qoshdr = 1'b1;
          else begin
            qos_d = fg_d[31:16];
            phase_d = PH_QOSSKIP;
          end
        end
      end
      PH_QOSSKIP: begin
        if (qos_q != 16'd0) qos_d = qos_q - 16'd1;
        if (qos_d == 16'd0) go_qoshdr = 1'b1;
      end
      PH_ENCAP: begin
        fg_d[hc_q[1:0]*8 +: 8] = data_byte_i;
        hc_d = hc_q + 5'd1;
        if (hc_d >= 5'd4) begin
          hc_d = '0;
          open_d = 1'b1;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        grp_o.kinds[n] = KIND_PAYLOAD;
        n = n + 2'd1;
      end
      default: ;
    endcase

    if (go_after_extra) begin
      if (flags_q[FlagQos]) go_qoshdr = 1'b1;
      else go_encap = 1'b1;
    end
    if (go_qoshdr) begin
      phase_d = PH_QOSHDR;
      hc_d = '0;
      fg_d = '0;
    end
    if (go_encap) begin
      if (flags_q[FlagData]) begin
        phase_d = PH_ENCAP;
        hc_d = '0;
        fg_d = '0;
      end else begin
        phase_d = PH_SKIP;
      end
    end

    if (emit_prefix) begin
      grp_o.kinds[n] = KIND_PREFIX;
      n = n + 2'd1;
      grp_o.prefix_high = {prefix_d[0], prefix_d[1], prefix_d[2], prefix_d[3]};
      grp_o.prefix_low = {prefix_d[4], prefix_d[5], prefix_d[6], prefix_d[7],
                          prefix_d[8], prefix_d[9], prefix_d[10], prefix_d[11]};
    end

    if (in_content && !rest_q) begin
      if (content_q != 16'd0) content_d = content_q - 16'd1;
      if (content_d == 16'd0) begin
        if (open_d) begin
          grp_o.kinds[n] = KIND_COMMIT;
          n = n + 2'd1;
          open_d = 1'b0;
        end
        hc_d = '0;
        sh_d = '0;
        phase_d = (pos_d != 2'd0) ? PH_ALIGN : PH_SUBHDR;
      end
    end

    grp_o.payload_byte = data_byte_i;
    grp_o.reader_id = reader_d;
    grp_o.writer_id = writer_d;
    grp_o.sequence_number = seq_d;
    grp_o.pl_cdr = (fg_d[15:0] == SchemePlCdr);
    grp_o.status = ST_OK;

    if (eom_i) begin
      if (open_d) begin
        grp_o.kinds[n] = rest_d ? KIND_COMMIT : KIND_DISCARD;
        n = n + 2'd1;
      end
      if (phase_d == PH_HEADER) grp_o.status = ST_SHORT;
      else if (phase_d == PH_DRAIN) grp_o.status = ST_BAD_MAGIC;
      grp_o.kinds[n] = KIND_END;
      n = n + 2'd1;
      phase_d = PH_HEADER;
      hc_d = '0;
      pos_d = '0;
      magic_d = 1'b1;
      sh_d = '0;
      content_d = '0;
      rest_d = 1'b0;
      fg_d = '0;
      extra_d = '0;
      qos_d = '0;
      reader_d = '0;
      writer_d = '0;
      seq_d = '0;
      open_d = 1'b0;
      flags_d = '0;
    end
    grp_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hc_q <= '0;
      pos_q <= '0;
      magic_q <= 1'b1;
      sh_q <= '0;
      content_q <= '0;
      rest_q <= 1'b0;
      fg_q <= '0;
      extra_q <= '0;
      qos_q <= '0;
      reader_q <= '0;
      writer_q <= '0;
      seq_q <= '0;
      open_q <= 1'b0;
      flags_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hc_q <= hc_d;
      pos_q <= pos_d;
      magic_q <= magic_d;
      sh_q <= sh_d;
      content_q <= content_d;
      rest_q <= rest_d;
      fg_q <= fg_d;
      extra_q <= extra_d;
      qos_q <= qos_d;
      reader_q <= reader_d;
      writer_q <= writer_d;
      seq_q <= seq_d;
      open_q <= open_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) prefix_q <= prefix_d;
  end

endmodule

@@ src/rmd_result_buf.sv @@
// Result group register: holds the results of one byte and sends them one per transfer.
// Depends on rmd_pkg.
module rmd_result_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  rmd_pkg::grp_t grp_i,
  output logic          load_ok_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [rmd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [2:0]    m_axis_tuser,
  output logic          m_axis_tlast
);
  import rmd_pkg::*;

  grp_t       grp_q;
  logic       vld_q;
  logic [1:0] idx_q;
  logic       is_last;
  logic       xfer;
  kind_e      kind;

  assign kind = grp_q.kinds[idx_q];
  assign is_last = (idx_q == grp_q.cnt - 2'd1);
  assign xfer = vld_q && m_axis_tready;
  assign load_ok_o = !vld_q || (xfer && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load_i) begin
      vld_q <= (grp_i.cnt != 2'd0);
      idx_q <= '0;
    end else if (xfer) begin
      if (is_last) vld_q <= 1'b0;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) grp_q <= grp_i;
  end

  always_comb begin
    logic       is_data;
    is_data = (kind == KIND_PAYLOAD) || (kind == KIND_COMMIT) || (kind == KIND_DISCARD);
    m_axis_tdata = '0;
    m_axis_tdata[7:0] = (kind == KIND_PAYLOAD) ? grp_q.payload_byte : 8'd0;
    if (is_data) begin
      m_axis_tdata[39:8] = grp_q.reader_id;
      m_axis_tdata[71:40] = grp_q.writer_id;
      m_axis_tdata[135:72] = grp_q.sequence_number;
      m_axis_tdata[136] = grp_q.pl_cdr;
    end
    if (kind == KIND_PREFIX) begin
      m_axis_tdata[168:137] = grp_q.prefix_high;
      m_axis_tdata[232:169] = grp_q.prefix_low;
    end
    if (kind == KIND_END) m_axis_tdata[234:233] = grp_q.status;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser = kind;
  assign m_axis_tlast = is_last;

endmodule

@@ src/rtps_message_deframer.sv @@
// Top level of the RTPS message deframer: input register, parser, result buffer.
// Depends on rmd_pkg, rmd_parser and rmd_result_buf.
//
// channel | dir | tdata                        | tuser | tlast
// s_axis  | in  | data_byte                    | -     | end_of_message
// m_axis  | out | result fields (see port)     | kind  | last
//
// One byte per cycle when each byte makes at most one result and m_axis is
// not stalled; a byte making two or three results holds the input register
// while the result buffer sends them. A byte passes the input register, then
// the result buffer register. Reset clears all parse state; the prefix bytes
// are not reset. An empty input register takes a byte while a result waits.
module rtps_message_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [39:8] reader_id, [71:40] writer_id,
  // [135:72] sequence_number, [136] pl_cdr, [168:137] prefix_high,
  // [232:169] prefix_low, [234:233] message_status, [239:235] zero
  output logic [rmd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);
  import rmd_pkg::*;

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       eom_q;
  logic       load_ok;
  logic       step;
  grp_t       grp;

  assign step = in_vld_q && load_ok;
  assign s_axis_tready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata;
      eom_q <= s_axis_tlast;
    end
  end

  rmd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (byte_q),
    .eom_i       (eom_q),
    .grp_o       (grp)
  );

  rmd_result_buf u_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step),
    .grp_i         (grp),
    .load_ok_o     (load_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ src/rmd_checker.sv @@
// Port-level checks for the RTPS message deframer, bound to the top level.
// Depends on rmd_pkg.
module rmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [rmd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import rmd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD |-> m_axis_tdata[7:0] == 8'd0)
    else $error("payload byte set on a non-payload result");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast)
    else $error("message end is not the last result of its byte");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_END |-> m_axis_tdata[234:233] == 2'd0)
    else $error("status set on a result other than message end");

endmodule

bind rtps_message_deframer rmd_checker u_rmd_checker (.*);
